[hw/rtl/latest_snapshot_slot_mailbox_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the latest snapshot slot mailbox
// Shorthand for clocked implication checks disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef LATEST_SNAPSHOT_SLOT_MAILBOX_ASSERT_SVH
`define LATEST_SNAPSHOT_SLOT_MAILBOX_ASSERT_SVH

// same-cycle implication
`define LSSM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSSM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lssm_pkg.sv]
// ----------------------------------------------------------------------------
// lssm_pkg
// Shared widths, operation and slot status codes, status write port bundle.
// ----------------------------------------------------------------------------
package lssm_pkg;

  localparam int OP_W          = 3;
  localparam int SLOT_W        = 3;
  localparam int SEQ_W         = 64;
  localparam int NUM_SLOTS_DEF = 4;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN_WRITE = 3'd0,
    OP_PUBLISH     = 3'd1,
    OP_CANCEL      = 3'd2,
    OP_ACQUIRE     = 3'd3,
    OP_RELEASE     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_FREE      = 2'd0,
    ST_WRITING   = 2'd1,
    ST_PUBLISHED = 2'd2,
    ST_READING   = 2'd3
  } slot_status_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_status_t      status;
  } status_wr_t;

endpackage

[hw/rtl/lssm_cmp.sv]
// ----------------------------------------------------------------------------
// lssm_cmp
// Shared 64-bit sequence magnitude comparator, used by both scan passes.
// ----------------------------------------------------------------------------
module lssm_cmp import lssm_pkg::*; (
  input  logic [SEQ_W-1:0] a,
  input  logic [SEQ_W-1:0] b,
  output logic             gt
);

  assign gt = (a > b);

endmodule

[hw/rtl/lssm_status.sv]
// ----------------------------------------------------------------------------
// lssm_status
// Per-slot status flops with one read port, one write port and a lowest
// Free slot finder.
// ----------------------------------------------------------------------------
module lssm_status import lssm_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic         clk,
  input  logic         rst,
  input  status_wr_t   wr,
  input  logic [IW-1:0] rd_addr,
  output slot_status_t rd_status,
  output logic         free_found,
  output logic [IW-1:0] free_idx
);

  slot_status_t status [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status[i] <= ST_FREE;
      end
    end else if (wr.en) begin
      status[wr.addr[IW-1:0]] <= wr.status;
    end
  end

  assign rd_status = status[rd_addr];

  // walk down so the lowest Free index is the one left standing
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (status[i] == ST_FREE) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

endmodule

[hw/rtl/latest_snapshot_slot_mailbox.sv]
// ----------------------------------------------------------------------------
// latest_snapshot_slot_mailbox
// Slot mailbox handing out write slots and the newest published snapshot.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high
// until its single result is shown for one cycle with done, which cannot be
// held off. begin_write, publish, cancel and unused codes finish in the
// execute state; release then frees the current reading slot. acquire_latest
// makes one pass over the slots through the shared comparator to find the
// newest published sequence, and ends there when nothing is published; it
// then frees the previous reading slot, makes a second pass that frees every
// older or equal published slot but the winner, and finally marks the winner
// as reading. Both passes read the sequence store through its one registered
// read port. dropped_count is live and steps at the edge that raises done
// for a failed begin_write.
module latest_snapshot_slot_mailbox import lssm_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [SLOT_W-1:0] slot,
  input  logic [SEQ_W-1:0]  sequence_req,
  output logic              done,
  output logic              granted,
  output logic [SLOT_W-1:0] slot_out,
  output logic [SEQ_W-1:0]  sequence_out,
  output logic [SEQ_W-1:0]  dropped_count
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_REL, S_PURGE, S_FIN
  } state_t;

  state_t            state;
  op_t               op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [CW-1:0]     cnt;
  logic              ev_vld;
  logic [IW-1:0]     ev_idx;
  logic [SEQ_W-1:0]  seq_rd;
  logic              found;
  logic [IW-1:0]     best_idx;
  logic [SEQ_W-1:0]  best_seq;
  logic              rd_vld;
  logic [IW-1:0]     rd_idx;
  logic [SEQ_W-1:0]  drop_counter;

  logic [SEQ_W-1:0]  seq_mem [NUM_SLOTS];

  status_wr_t        st_wr;
  logic [IW-1:0]     st_rd_addr;
  slot_status_t      st_rd;
  logic              free_found;
  logic [IW-1:0]     free_idx;
  logic              gt;
  logic              slot_ok;
  logic              mem_we;
  logic              scan_hit;
  logic              cnt_end;

  lssm_status #(.NUM_SLOTS(NUM_SLOTS)) u_status (
    .clk       (clk),
    .rst       (rst),
    .wr        (st_wr),
    .rd_addr   (st_rd_addr),
    .rd_status (st_rd),
    .free_found(free_found),
    .free_idx  (free_idx)
  );

  lssm_cmp u_cmp (
    .a (seq_rd),
    .b (best_seq),
    .gt(gt)
  );

  assign slot_ok  = ({1'b0, slot_q} < (SLOT_W + 1)'(NUM_SLOTS));
  assign mem_we   = (state == S_EXEC) && (op_q == OP_PUBLISH) && slot_ok;
  assign cnt_end  = (cnt == CW'(NUM_SLOTS));
  assign scan_hit = ev_vld && (st_rd == ST_PUBLISHED) && (!found || gt);

  // sequence store, registered read stepping with the scan counter
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[slot_q[IW-1:0]] <= seq_q;
    end
    seq_rd <= seq_mem[cnt[IW-1:0]];
  end

  always_comb begin
    unique case (state)
      S_EXEC:  st_rd_addr = slot_q[IW-1:0];
      S_REL:   st_rd_addr = rd_idx;
      default: st_rd_addr = ev_idx;
    endcase
  end

  always_comb begin
    st_wr = '{en: 1'b0, addr: '0, status: ST_FREE};
    unique case (state)
      S_EXEC: begin
        unique case (op_q)
          OP_BEGIN_WRITE: st_wr = '{en: free_found, addr: SLOT_W'(free_idx),
                                    status: ST_WRITING};
          OP_PUBLISH:     st_wr = '{en: slot_ok && (st_rd == ST_WRITING),
                                    addr: slot_q, status: ST_PUBLISHED};
          OP_CANCEL:      st_wr = '{en: slot_ok && (st_rd == ST_WRITING),
                                    addr: slot_q, status: ST_FREE};
          default:        st_wr = '{en: 1'b0, addr: '0, status: ST_FREE};
        endcase
      end
      S_REL:   st_wr = '{en: rd_vld && (st_rd == ST_READING),
                         addr: SLOT_W'(rd_idx), status: ST_FREE};
      // free older or equal published slots, winner excluded
      S_PURGE: st_wr = '{en: ev_vld && (ev_idx != best_idx) &&
                             (st_rd == ST_PUBLISHED) && !gt,
                         addr: SLOT_W'(ev_idx), status: ST_FREE};
      S_FIN:   st_wr = '{en: 1'b1, addr: SLOT_W'(best_idx), status: ST_READING};
      default: st_wr = '{en: 1'b0, addr: '0, status: ST_FREE};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      ev_vld       <= 1'b0;
      found        <= 1'b0;
      rd_vld       <= 1'b0;
      rd_idx       <= '0;
      cnt          <= '0;
      drop_counter <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q   <= op_t'(operation);
            slot_q <= slot;
            seq_q  <= sequence_req;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          granted      <= 1'b0;
          slot_out     <= '0;
          sequence_out <= '0;
          cnt          <= '0;
          ev_vld       <= 1'b0;
          found        <= 1'b0;
          unique case (op_q)
            OP_BEGIN_WRITE: begin
              if (free_found) begin
                granted  <= 1'b1;
                slot_out <= SLOT_W'(free_idx);
              end else begin
                drop_counter <= drop_counter + SEQ_W'(1);
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            OP_ACQUIRE: state <= S_SCAN;
            OP_RELEASE: state <= S_REL;
            default: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_SCAN: begin
          if (!cnt_end) begin
            cnt    <= cnt + CW'(1);
            ev_vld <= 1'b1;
            ev_idx <= cnt[IW-1:0];
          end else begin
            ev_vld <= 1'b0;
          end
          if (scan_hit) begin
            found    <= 1'b1;
            best_idx <= ev_idx;
            best_seq <= seq_rd;
          end
          if (cnt_end) begin
            if (found || scan_hit) begin
              state <= S_REL;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_REL: begin
          rd_vld <= 1'b0;
          cnt    <= '0;
          ev_vld <= 1'b0;
          if (op_q == OP_ACQUIRE) begin
            state <= S_PURGE;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_PURGE: begin
          if (!cnt_end) begin
            cnt    <= cnt + CW'(1);
            ev_vld <= 1'b1;
            ev_idx <= cnt[IW-1:0];
          end else begin
            ev_vld <= 1'b0;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          rd_vld       <= 1'b1;
          rd_idx       <= best_idx;
          granted      <= 1'b1;
          slot_out     <= SLOT_W'(best_idx);
          sequence_out <= best_seq;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state != S_IDLE);
  assign dropped_count = drop_counter;

endmodule

[hw/rtl/lssm_checker.sv]
// ----------------------------------------------------------------------------
// lssm_checker
// Port-level checks on command and result timing of the slot mailbox.
// ----------------------------------------------------------------------------
`include "latest_snapshot_slot_mailbox_assert.svh"

module lssm_checker import lssm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              granted,
  input logic [SLOT_W-1:0] slot_out,
  input logic [SEQ_W-1:0]  sequence_out,
  input logic [SEQ_W-1:0]  dropped_count
);

  // an accepted command keeps the block busy in the following cycle
  `LSSM_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accept without busy")

  // a result transfer only appears as the block returns to idle
  `LSSM_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "done while busy")

  `LSSM_ASSERT_NXT(a_done_single, clk, rst, done, !done, "done longer than one cycle")

  `LSSM_ASSERT_IMP(a_no_grant_zero, clk, rst, done && !granted, (slot_out == '0) && (sequence_out == '0), "ungranted result not zero")

  // drop count moves only with a delivered result
  `LSSM_ASSERT_IMP(a_drop_on_done, clk, rst, !done && !$past(rst), $stable(dropped_count), "drop count moved without result")

endmodule

bind latest_snapshot_slot_mailbox lssm_checker u_lssm_checker (.*);
